[rtl/gf64i_pkg.sv]
// ----------------------------------------------------------------------------
// GF(2^64) inverse package
// Types and constants shared by the field inverse block.
// ----------------------------------------------------------------------------
package gf64i_pkg;

    localparam int WORD_BITS = 64;

    localparam logic [WORD_BITS-1:0] POLY_RESET = 64'h0000_0000_0000_001b;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_NORM   = 3'b010,
        ST_REDUCE = 3'b100
    } t_state;

endpackage

[rtl/gf2_64_field_inverse.sv]
// ----------------------------------------------------------------------------
// GF(2^64) field inverse
// Returns the multiplicative inverse of one element modulo a programmable
// reduction polynomial, or a flag when the element has no inverse.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_ready, i_value) takes one element per
// transfer; o_ready is high only while no element is being worked on. The
// output channel (o_valid, i_ready, o_inverse, o_not_invertible) delivers one
// result per element from an output register, so a new element is taken
// while the previous result still waits. The configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_data) writes the low terms of the modulus
// and is always ready; the user must write it only while the block is idle,
// as the block does not enforce this. The element is inverted by a polynomial
// extended Euclid algorithm on one shared shift and XOR unit, one step per
// cycle: the remainders are kept normalized by single-bit shifts and each
// quotient bit is one XOR step. The number of steps depends on the data; the
// next element is taken in the cycle after the result is written. An element
// that shares a factor with the modulus, zero included, returns zero with
// o_not_invertible set.
// Reset returns the modulus low terms to 0x1b and drops any work in flight.
// When the receiver stalls, a finished result waits in the output register
// and a following computation holds at its last step until the register frees.
// ----------------------------------------------------------------------------
module gf2_64_field_inverse #(
    parameter int FIELD_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gf64i_pkg::WORD_BITS-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [gf64i_pkg::WORD_BITS-1:0] i_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [gf64i_pkg::WORD_BITS-1:0] o_inverse,
    output logic                            o_not_invertible
);

    localparam int N  = FIELD_BITS;
    localparam int DW = $clog2(N + 1);

    gf64i_pkg::t_state r_state, n_state;

    logic [gf64i_pkg::WORD_BITS-1:0] r_poly;
    logic [N:0]                      r_ra, n_ra;
    logic [N:0]                      r_rb, n_rb;
    logic [N:0]                      r_ta, n_ta;
    logic [N:0]                      r_sb, n_sb;
    logic [DW-1:0]                   r_da, n_da;
    logic [DW-1:0]                   r_db, n_db;
    logic                            r_out_valid, n_out_valid;
    logic [gf64i_pkg::WORD_BITS-1:0] r_inverse, n_inverse;
    logic                            r_fail, n_fail;

    logic       w_hit;
    logic       w_out_free;
    logic [N:0] w_ra_x;
    logic [N:0] w_ta_x;
    logic [N:0] w_rem;

    assign w_hit      = r_ra[N];
    assign w_ra_x     = w_hit ? (r_ra ^ r_rb) : r_ra;
    assign w_ta_x     = w_hit ? (r_ta ^ r_sb) : r_ta;
    assign w_rem      = {w_ra_x[N-1:0], 1'b0};
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_ta        = r_ta;
        n_sb        = r_sb;
        n_da        = r_da;
        n_db        = r_db;
        n_out_valid = r_out_valid && !i_ready;
        n_inverse   = r_inverse;
        n_fail      = r_fail;
        case (r_state)
            gf64i_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_ra    = {1'b1, r_poly[N-1:0]};
                    n_da    = DW'(N);
                    n_ta    = '0;
                    n_rb    = {1'b0, i_value[N-1:0]};
                    n_db    = DW'(N);
                    n_sb    = (N + 1)'(1);
                    n_state = gf64i_pkg::ST_NORM;
                end
            end
            gf64i_pkg::ST_NORM: begin
                if (r_rb == '0) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_inverse   = '0;
                        n_fail      = 1'b1;
                        n_state     = gf64i_pkg::ST_IDLE;
                    end
                end else if (r_rb[N]) begin
                    n_state = gf64i_pkg::ST_REDUCE;
                end else begin
                    n_rb = {r_rb[N-1:0], 1'b0};
                    n_sb = {r_sb[N-1:0], 1'b0};
                    n_db = r_db - DW'(1);
                end
            end
            gf64i_pkg::ST_REDUCE: begin
                if (r_da != r_db) begin
                    n_ra = w_rem;
                    n_ta = w_ta_x;
                    n_sb = r_sb >> 1;
                    n_da = r_da - DW'(1);
                end else if (w_rem == '0) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_fail      = (r_db != '0);
                        n_inverse   = (r_db == '0) ?
                                      gf64i_pkg::WORD_BITS'(r_sb[N-1:0]) : '0;
                        n_state     = gf64i_pkg::ST_IDLE;
                    end
                end else begin
                    n_ra    = r_rb;
                    n_da    = r_db;
                    n_ta    = r_sb;
                    n_rb    = w_rem;
                    n_db    = r_db - DW'(1);
                    n_sb    = {w_ta_x[N-1:0], 1'b0};
                    n_state = gf64i_pkg::ST_NORM;
                end
            end
            default: begin
                n_state = gf64i_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gf64i_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_poly      <= gf64i_pkg::POLY_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_poly <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra      <= n_ra;
        r_rb      <= n_rb;
        r_ta      <= n_ta;
        r_sb      <= n_sb;
        r_da      <= n_da;
        r_db      <= n_db;
        r_inverse <= n_inverse;
        r_fail    <= n_fail;
    end

    assign o_cfg_ready      = 1'b1;
    assign o_ready          = (r_state == gf64i_pkg::ST_IDLE);
    assign o_valid          = r_out_valid;
    assign o_inverse        = r_inverse;
    assign o_not_invertible = r_fail;

`ifndef NO_ASSERTIONS
    a_degree_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gf64i_pkg::ST_IDLE) |-> (r_db <= r_da))
        else $error("Divisor degree exceeds dividend degree.");

    a_divisor_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gf64i_pkg::ST_REDUCE) |-> r_rb[N])
        else $error("Divisor is not normalized during reduction.");

    a_fail_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fail) |-> (r_inverse == '0))
        else $error("Non-invertible result carries a nonzero value.");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == gf64i_pkg::ST_NORM))
        else $error("Accepted element did not start the computation.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_inverse)
                                       && $stable(r_fail)))
        else $error("Pending result was overwritten.");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GF(2^64) field inverse testbench
// Drives elements into the inverse block under several reduction polynomials
// and idle patterns, and compares every result with a matrix-inversion
// predictor or with an expected value listed in the directed rows.
// ----------------------------------------------------------------------------
module tb;

    localparam int W            = gf64i_pkg::WORD_BITS;
    localparam int HOLD_CYCLES  = 600;
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 150;
    localparam int SHOWN_LIMIT  = 10;

    typedef logic [W-1:0] t_word;

    typedef struct packed {
        t_word inverse;
        logic  not_invertible;
    } t_inv_result;

    typedef struct packed {
        logic        set_poly;
        t_word       poly;
        t_word       value;
        logic        literal;
        t_inv_result want;
    } t_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_cfg_valid = 1'b0;
    logic  o_cfg_ready;
    t_word i_cfg_data = '0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_word i_value = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_word o_inverse;
    logic  o_not_invertible;

    t_inv_result pending_inverses[$];
    t_word       poly_now = gf64i_pkg::POLY_RESET;
    bit          offering = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned mismatch_count = 0;
    t_row        directed_rows [21];

    gf2_64_field_inverse #(
        .FIELD_BITS(W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_inverse       (o_inverse),
        .o_not_invertible(o_not_invertible)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_inv_result field_inverse_of(t_word a, t_word poly);
        t_word       rows [W];
        t_word       track [W];
        t_word       tmp;
        t_inv_result res;
        int          piv;
        res.inverse = '0;
        res.not_invertible = 1'b1;
        for (int r = 0; r < W; r++) begin
            rows[r] = a;
            track[r] = t_word'(1) << r;
            a = {a[W-2:0], 1'b0} ^ (a[W-1] ? poly : t_word'(0));
        end
        for (int c = 0; c < W; c++) begin
            if (!rows[c][c]) begin
                piv = c + 1;
                while (piv < W && !rows[piv][c]) piv++;
                if (piv == W) return res;
                tmp = rows[c]; rows[c] = rows[piv]; rows[piv] = tmp;
                tmp = track[c]; track[c] = track[piv]; track[piv] = tmp;
            end
            for (int r = c + 1; r < W; r++) begin
                if (rows[r][c]) begin
                    rows[r] ^= rows[c];
                    track[r] ^= track[c];
                end
            end
        end
        for (int c = W - 1; c >= 0; c--) begin
            for (int r = 0; r < c; r++) begin
                if (rows[r][c]) begin
                    rows[r] ^= rows[c];
                    track[r] ^= track[c];
                end
            end
        end
        res.inverse = track[0];
        res.not_invertible = 1'b0;
        return res;
    endfunction

    function automatic t_word pick_element();
        t_word bit_k;
        bit_k = t_word'(1) << $urandom_range(W - 1);
        case ($urandom_range(15))
            0:       return '0;
            1:       return t_word'(1);
            2:       return bit_k;
            3:       return '1;
            4:       return ~bit_k;
            5:       return t_word'($urandom_range(255));
            6:       return {$urandom, 32'h0};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic count_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= SHOWN_LIMIT) begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
    endtask

    task automatic settle_outputs();
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
            @(posedge i_clk);
        end
        while (pending_inverses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_poly(input t_word p);
        settle_outputs();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= p;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        poly_now = p;
    endtask

    task automatic offer_value(input t_word v, input logic literal, input t_inv_result want);
        i_valid <= 1'b1;
        i_value <= v;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_inverses.push_back(literal ? want : field_inverse_of(v, poly_now));
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_value <= {$urandom, $urandom};
            offering = 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            i_ready <= 1'b0;
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_inv_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_inverses.size() == 0) begin
                count_mismatch($sformatf("unexpected result inverse=%h flag=%b",
                                         o_inverse, o_not_invertible));
            end else begin
                want = pending_inverses.pop_front();
                if (o_inverse !== want.inverse || o_not_invertible !== want.not_invertible) begin
                    count_mismatch($sformatf("expected %h/%b, got %h/%b",
                                             want.inverse, want.not_invertible,
                                             o_inverse, o_not_invertible));
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        t_word seg_poly;
        directed_rows = '{
            '{1'b0, 64'h0, 64'h0, 1'b1, '{64'h0, 1'b1}},
            '{1'b0, 64'h0, 64'h1, 1'b1, '{64'h1, 1'b0}},
            '{1'b0, 64'h0, 64'h2, 1'b1, '{64'h8000_0000_0000_000d, 1'b0}},
            '{1'b0, 64'h0, 64'h8000_0000_0000_000d, 1'b1, '{64'h2, 1'b0}},
            '{1'b0, 64'h0, 64'h8000_0000_0000_0000, 1'b0, '{64'h0, 1'b0}},
            '{1'b0, 64'h0, 64'hffff_ffff_ffff_ffff, 1'b0, '{64'h0, 1'b0}},
            '{1'b0, 64'h0, 64'h1b, 1'b0, '{64'h0, 1'b0}},
            '{1'b0, 64'h0, 64'h5555_5555_5555_5555, 1'b0, '{64'h0, 1'b0}},
            '{1'b0, 64'h0, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '{64'h0, 1'b0}},
            '{1'b0, 64'h0, 64'h0123_4567_89ab_cdef, 1'b0, '{64'h0, 1'b0}},
            '{1'b1, 64'hffff_ffff_ffff_ffff, 64'h1, 1'b1, '{64'h1, 1'b0}},
            '{1'b0, 64'h0, 64'h0, 1'b1, '{64'h0, 1'b1}},
            '{1'b0, 64'h0, 64'hffff_ffff_ffff_ffff, 1'b0, '{64'h0, 1'b0}},
            '{1'b0, 64'h0, 64'h3, 1'b0, '{64'h0, 1'b0}},
            '{1'b0, 64'h0, 64'h8000_0000_0000_0000, 1'b0, '{64'h0, 1'b0}},
            '{1'b1, 64'h0, 64'h2, 1'b1, '{64'h0, 1'b1}},
            '{1'b0, 64'h0, 64'h1, 1'b1, '{64'h1, 1'b0}},
            '{1'b0, 64'h0, 64'hffff_ffff_ffff_ffff, 1'b0, '{64'h0, 1'b0}},
            '{1'b0, 64'h0, 64'h8000_0000_0000_0000, 1'b1, '{64'h0, 1'b1}},
            '{1'b0, 64'h0, 64'h3, 1'b0, '{64'h0, 1'b0}},
            '{1'b1, 64'h1b, 64'hfedc_ba98_7654_3210, 1'b0, '{64'h0, 1'b0}}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_poly) write_poly(directed_rows[i].poly);
            offer_value(directed_rows[i].value, directed_rows[i].literal, directed_rows[i].want);
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0, 7:    seg_poly = gf64i_pkg::POLY_RESET;
                2:       seg_poly = '1;
                3:       seg_poly = {$urandom, $urandom} & ~t_word'(1);
                4:       seg_poly = '0;
                default: seg_poly = {$urandom, $urandom};
            endcase
            write_poly(seg_poly);
            case (seg % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 51;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 51;
                end
                default: begin
                    send_idle_pct = 33;
                    recv_stall_pct <= 33;
                end
            endcase
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if (n == 40 && (seg == 0 || seg == 5)) hold_requests <= hold_requests + 1;
                if (n == 90 && seg == 2) settle_outputs();
                offer_value(pick_element(), 1'b0, '0);
            end
        end

        settle_outputs();
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0 && pending_inverses.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
